[src/pfa_pkg.sv]
// shared widths, codes and state encoding for the page fit allocator
package pfa_pkg;

  // fixed field widths of the request and response transactions
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned START_W  = 5;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned FRAG_W   = 5;

  // configuration port
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 2;
  localparam logic [APB_AW-1:0] REG_FIT_POLICY = 2'd0;

  // fit policy codes
  localparam logic POL_BEST  = 1'b0;
  localparam logic POL_WORST = 1'b1;

  // request modes, the unused code behaves as a query
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_KILL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // owner id that marks a free page
  localparam logic [ID_W-1:0] ID_FREE = 8'd0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_HOLE = 2'd1,
    ST_PRESENT = 2'd2,
    ST_ZERO    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_FILL,
    S_DONE
  } state_e;

endpackage

[src/pfa_req_if.sv]
// request channel: mode, program id and size with valid/ready
interface pfa_req_if import pfa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   program_id;
  logic [SIZE_W-1:0] size_kb;

  modport source (output valid, mode, program_id, size_kb, input ready);
  modport sink   (input valid, mode, program_id, size_kb, output ready);
endinterface

[src/pfa_rsp_if.sv]
// response channel: status, allocation and fragment count with valid/ready
interface pfa_rsp_if import pfa_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  start_page;
  logic [COUNT_W-1:0]  page_count;
  logic [FRAG_W-1:0]   fragment_count;

  modport source (output valid, status, start_page, page_count, fragment_count, input ready);
  modport sink   (input valid, status, start_page, page_count, fragment_count, output ready);
endinterface

[src/page_fit_allocator.sv]
// page owner table with best-fit / worst-fit allocation, kill and fragment query
//
// The owner of every page sits in a single-port-write memory with a registered
// read; a flip-flop per page marks entries written since reset, so an unwritten
// page reads as free and no clearing pass is needed. A request is taken only
// while the block is idle. Each transaction then streams all NUM_PAGES entries
// through the memory read port once, during which it checks for the id, tracks
// the chosen hole, counts free fragments and, for a kill, writes freed pages
// back behind the read pointer. An evaluation state follows, then an add writes
// its pages one per cycle, then the result is moved into the output register and
// the block turns idle to take the next request. The output register holds a
// finished result while the next request is already being worked on; a result
// still waiting there holds the following one back in its last cycle.
// fit_policy is written at byte address 0 of the APB port and reads back there.
module page_fit_allocator import pfa_pkg::*; #(
  parameter int unsigned NUM_PAGES = 32,
  parameter int unsigned PAGE_KB   = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pfa_req_if.sink           req_i,
  pfa_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned IDX_W  = $clog2(NUM_PAGES);
  localparam int unsigned CNT_W  = $clog2(NUM_PAGES + 1);
  localparam int unsigned PKB_W  = $clog2(PAGE_KB + 1);
  localparam int unsigned PROD_W = CNT_W + PKB_W;
  localparam int unsigned CMP_W  = (PROD_W > SIZE_W) ? PROD_W : SIZE_W;
  localparam int unsigned ACC_W  = SIZE_W + 1;

  // configuration register
  logic fit_policy_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_FIT_POLICY);
  assign prdata = (paddr == REG_FIT_POLICY) ? APB_DW'(fit_policy_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q <= POL_BEST;
    end else if (cfg_wr) begin
      fit_policy_q <= pwdata[0];
    end
  end

  // control and datapath registers
  state_e              state_q, state_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [ID_W-1:0]     id_q, id_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [CNT_W-1:0]    rd_cnt_q, rd_cnt_d;
  logic                proc_vld_q, proc_vld_d;
  logic [IDX_W-1:0]    proc_idx_q, proc_idx_d;
  logic                prev_free_q, prev_free_d;
  logic [CNT_W-1:0]    run_len_q, run_len_d;
  logic [IDX_W-1:0]    run_start_q, run_start_d;
  logic [CNT_W-1:0]    frag_q, frag_d;
  logic                found_q, found_d;
  logic                present_q, present_d;
  logic [CNT_W-1:0]    best_len_q, best_len_d;
  logic [IDX_W-1:0]    best_start_q, best_start_d;
  logic [CNT_W-1:0]    res_count_q, res_count_d;
  logic [IDX_W-1:0]    res_start_q, res_start_d;
  status_e             res_status_q, res_status_d;
  logic [CNT_W-1:0]    fill_cnt_q, fill_cnt_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic                out_vld_q, out_vld_d;
  status_e             out_status_q, out_status_d;
  logic [START_W-1:0]  out_start_q, out_start_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;
  logic [FRAG_W-1:0]   out_frag_q, out_frag_d;

  // owner memory, written at one address and read at one per cycle
  logic [ID_W-1:0]      mem_q [NUM_PAGES];
  logic [ID_W-1:0]      mem_rd_q;
  logic [NUM_PAGES-1:0] pg_vld_q;
  logic                 rd_live_q;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ID_W-1:0]      mem_wdata;
  logic [IDX_W-1:0]     rd_addr;

  assign rd_addr = rd_cnt_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rd_q <= mem_q[rd_addr];
  end

  // written-since-reset flags, an unwritten page reads as free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pg_vld_q  <= '0;
      rd_live_q <= 1'b0;
    end else begin
      rd_live_q <= pg_vld_q[rd_addr];
      if (mem_we) begin
        pg_vld_q[mem_waddr] <= 1'b1;
      end
    end
  end

  // per-page scan logic on the entry returned by the memory
  logic [ID_W-1:0]  owner;
  logic             is_kill;
  logic             kill_hit;
  logic             post_free;
  logic             is_last;
  logic [CNT_W-1:0] cur_len;
  logic [IDX_W-1:0] cur_start;
  logic             cand_vld;
  logic [CNT_W-1:0] cand_len;
  logic [IDX_W-1:0] cand_start;
  logic [CMP_W-1:0] cand_kb;
  logic             fits;
  logic             better;
  logic             take;

  assign owner     = rd_live_q ? mem_rd_q : ID_FREE;
  assign is_kill   = (mode_q == MODE_KILL);
  assign kill_hit  = is_kill && (id_q != ID_FREE) && (owner == id_q);
  assign post_free = (owner == ID_FREE) || kill_hit;
  assign is_last   = (proc_idx_q == IDX_W'(NUM_PAGES - 1));
  assign cur_len   = prev_free_q ? (run_len_q + CNT_W'(1)) : CNT_W'(1);
  assign cur_start = prev_free_q ? run_start_q : proc_idx_q;

  // a hole closes on a busy page after a free one, or at the end of the table
  always_comb begin
    cand_vld   = 1'b0;
    cand_len   = run_len_q;
    cand_start = run_start_q;
    if (prev_free_q && !post_free) begin
      cand_vld = 1'b1;
    end else if (is_last && post_free) begin
      cand_vld   = 1'b1;
      cand_len   = cur_len;
      cand_start = cur_start;
    end
  end

  // hole large enough when len * PAGE_KB covers the request in KB
  assign cand_kb = CMP_W'(cand_len) * CMP_W'(PAGE_KB);
  assign fits    = (cand_kb >= CMP_W'(size_q));
  assign better  = !found_q ||
                   ((fit_policy_q == POL_BEST)  && (cand_len < best_len_q)) ||
                   ((fit_policy_q == POL_WORST) && (cand_len > best_len_q));
  assign take    = proc_vld_q && cand_vld && fits && better;

  // fill address and completion
  logic [CNT_W:0]   fill_sum;
  logic [CNT_W-1:0] fill_next;
  logic [ACC_W-1:0] acc_next;
  logic             fill_last;

  assign fill_sum  = (CNT_W + 1)'(best_start_q) + (CNT_W + 1)'(fill_cnt_q);
  assign fill_next = fill_cnt_q + CNT_W'(1);
  assign acc_next  = acc_q + ACC_W'(PAGE_KB);
  assign fill_last = (acc_next >= ACC_W'(size_q));

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.start_page     = out_start_q;
  assign rsp_o.page_count     = out_count_q;
  assign rsp_o.fragment_count = out_frag_q;

  // next state and datapath
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    id_d         = id_q;
    size_d       = size_q;
    rd_cnt_d     = rd_cnt_q;
    proc_vld_d   = 1'b0;
    proc_idx_d   = proc_idx_q;
    prev_free_d  = prev_free_q;
    run_len_d    = run_len_q;
    run_start_d  = run_start_q;
    frag_d       = frag_q;
    found_d      = found_q;
    present_d    = present_q;
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    res_count_d  = res_count_q;
    res_start_d  = res_start_q;
    res_status_d = res_status_q;
    fill_cnt_d   = fill_cnt_q;
    acc_d        = acc_q;
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_start_d  = out_start_q;
    out_count_d  = out_count_q;
    out_frag_d   = out_frag_q;
    mem_we       = 1'b0;
    mem_waddr    = proc_idx_q;
    mem_wdata    = ID_FREE;

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          mode_d       = req_i.mode;
          id_d         = req_i.program_id;
          size_d       = req_i.size_kb;
          rd_cnt_d     = '0;
          prev_free_d  = 1'b0;
          run_len_d    = '0;
          run_start_d  = '0;
          frag_d       = '0;
          found_d      = 1'b0;
          present_d    = 1'b0;
          best_len_d   = '0;
          best_start_d = '0;
          res_count_d  = '0;
          res_start_d  = '0;
          res_status_d = ST_OK;
          state_d      = S_SCAN;
        end
      end

      S_SCAN: begin
        // issue reads in page order
        if (rd_cnt_q < CNT_W'(NUM_PAGES)) begin
          proc_vld_d = 1'b1;
          proc_idx_d = rd_cnt_q[IDX_W-1:0];
          rd_cnt_d   = rd_cnt_q + CNT_W'(1);
        end
        // consume the entry read in the previous cycle
        if (proc_vld_q) begin
          prev_free_d = post_free;
          run_len_d   = cur_len;
          run_start_d = cur_start;
          if (post_free && !prev_free_q) begin
            frag_d = frag_q + CNT_W'(1);
          end
          if (owner == id_q) begin
            present_d = 1'b1;
          end
          // kill frees behind the read pointer, no overlap with the next read
          if (kill_hit) begin
            mem_we      = 1'b1;
            mem_waddr   = proc_idx_q;
            mem_wdata   = ID_FREE;
            res_count_d = res_count_q + CNT_W'(1);
          end
          if (take) begin
            found_d      = 1'b1;
            best_len_d   = cand_len;
            best_start_d = cand_start;
          end
          if (is_last) begin
            state_d = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        state_d = S_DONE;
        if (mode_q == MODE_ADD) begin
          if ((id_q == ID_FREE) || present_q) begin
            res_status_d = ST_PRESENT;
          end else if (size_q == '0) begin
            res_status_d = ST_ZERO;
          end else if (!found_q) begin
            res_status_d = ST_NO_HOLE;
          end else begin
            res_start_d = best_start_q;
            fill_cnt_d  = '0;
            acc_d       = '0;
            state_d     = S_FILL;
          end
        end
      end

      S_FILL: begin
        mem_we     = 1'b1;
        mem_waddr  = fill_sum[IDX_W-1:0];
        mem_wdata  = id_q;
        fill_cnt_d = fill_next;
        acc_d      = acc_next;
        if (fill_last) begin
          res_count_d = fill_next;
          // an exact fit removes the hole from the fragment count
          if (fill_next == best_len_q) begin
            frag_d = frag_q - CNT_W'(1);
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_start_d  = START_W'(res_start_q);
          out_count_d  = COUNT_W'(res_count_q);
          out_frag_d   = FRAG_W'(frag_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      proc_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      proc_vld_q <= proc_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // datapath registers, loaded before use
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    id_q         <= id_d;
    size_q       <= size_d;
    rd_cnt_q     <= rd_cnt_d;
    proc_idx_q   <= proc_idx_d;
    prev_free_q  <= prev_free_d;
    run_len_q    <= run_len_d;
    run_start_q  <= run_start_d;
    frag_q       <= frag_d;
    found_q      <= found_d;
    present_q    <= present_d;
    best_len_q   <= best_len_d;
    best_start_q <= best_start_d;
    res_count_q  <= res_count_d;
    res_start_q  <= res_start_d;
    res_status_q <= res_status_d;
    fill_cnt_q   <= fill_cnt_d;
    acc_q        <= acc_d;
    out_status_q <= out_status_d;
    out_start_q  <= out_start_d;
    out_count_q  <= out_count_d;
    out_frag_q   <= out_frag_d;
  end

  // fill never runs past the chosen hole
  a_fill_in_hole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (fill_cnt_q < best_len_q))
    else $error("fill ran past the chosen hole");

  // fill address stays inside the table
  a_fill_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (fill_sum < (CNT_W + 1)'(NUM_PAGES)))
    else $error("fill address outside the page table");

  // free fragments can never outnumber alternating pages
  a_frag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> (frag_q <= CNT_W'((NUM_PAGES + 1) / 2)))
    else $error("fragment count out of range");

  // the scan ends in the cycle after the last read was issued
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && proc_vld_q && is_last |->
      (rd_cnt_q == CNT_W'(NUM_PAGES)))
    else $error("scan read pointer out of step with the processed page");

endmodule
